>>> sv/mmlc_pkg.sv
// Shared types, constants and helper functions of the memory map line classifier.
package mmlc_pkg;

   // Field widths
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned CLASS_W  = 3;
   localparam int unsigned KB_W     = 54;
   localparam int unsigned CNT_W    = 63;
   localparam int unsigned CNT_N    = 8;
   localparam int unsigned RANGE_W  = 64;
   localparam int unsigned KIB_SHIFT = 10;   // KiB = bytes / 1024
   localparam int unsigned OUT_BITS = KB_W + CNT_N * CNT_W;
   localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
   localparam int unsigned OUT_PAD_W = OUT_TDATA_W - OUT_BITS;

   // Default kept line length
   localparam int unsigned LINE_KEEP_DEF = 2047;

   // Characters of interest
   localparam logic [BYTE_W-1:0] CHAR_NUL    = 8'h00;
   localparam logic [BYTE_W-1:0] CHAR_NL     = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_SPACE  = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_DASH   = 8'h2D;
   localparam logic [BYTE_W-1:0] CHAR_LBRACK = 8'h5B;

   // Tag patterns, first character in the lowest byte
   localparam int unsigned SEC_LEN = 21;
   localparam logic [SEC_LEN*8-1:0] PAT_SEC = {
      8'h79, 8'h72, 8'h61, 8'h64, 8'h6E, 8'h6F, 8'h63, 8'h65, 8'h73, 8'h3A, 8'h6F,
      8'h64, 8'h75, 8'h63, 8'h73, 8'h3A, 8'h6E, 8'h6F, 8'h6E, 8'h61, 8'h5B};
   localparam int unsigned PRI_LEN = 19;
   localparam logic [PRI_LEN*8-1:0] PAT_PRI = {
      8'h79, 8'h72, 8'h61, 8'h6D, 8'h69, 8'h72, 8'h70, 8'h3A, 8'h6F, 8'h64,
      8'h75, 8'h63, 8'h73, 8'h3A, 8'h6E, 8'h6F, 8'h6E, 8'h61, 8'h5B};
   localparam int unsigned STK_LEN = 19;
   localparam logic [STK_LEN*8-1:0] PAT_STK = {
      8'h73, 8'h6C, 8'h74, 8'h5F, 8'h64, 8'h6E, 8'h61, 8'h5F, 8'h6B, 8'h63,
      8'h61, 8'h74, 8'h73, 8'h3A, 8'h6E, 8'h6F, 8'h6E, 8'h61, 8'h5B};
   localparam int unsigned RT_LEN = 13;
   localparam logic [RT_LEN*8-1:0] PAT_RT = {
      8'h2D, 8'h6B, 8'h69, 8'h76, 8'h6C, 8'h61, 8'h64, 8'h3A, 8'h6E, 8'h6F,
      8'h6E, 8'h61, 8'h5B};
   // Suffix that rejects a primary match
   localparam int unsigned RES_LEN = 8;
   localparam logic [RES_LEN*8-1:0] PAT_RES = {
      8'h65, 8'h76, 8'h72, 8'h65, 8'h73, 8'h65, 8'h72, 8'h5F};

   // Line classes
   localparam logic [CLASS_W-1:0] CLASS_SECONDARY = 3'd0;
   localparam logic [CLASS_W-1:0] CLASS_PRIMARY   = 3'd1;
   localparam logic [CLASS_W-1:0] CLASS_STACK     = 3'd2;
   localparam logic [CLASS_W-1:0] CLASS_RUNTIME   = 3'd3;
   localparam logic [CLASS_W-1:0] CLASS_OTHER     = 3'd4;
   localparam logic [CLASS_W-1:0] CLASS_NONE      = 3'd5;

   // Found flag bits
   localparam int unsigned FLAG_W   = 5;
   localparam int unsigned FLAG_SEC = 0;
   localparam int unsigned FLAG_PRI = 1;
   localparam int unsigned FLAG_REJ = 2;
   localparam int unsigned FLAG_STK = 3;
   localparam int unsigned FLAG_RT  = 4;

   // Hex range parse phases
   localparam int unsigned PH_W = 2;
   localparam logic [PH_W-1:0] PH_START = 2'd0;
   localparam logic [PH_W-1:0] PH_END   = 2'd1;
   localparam logic [PH_W-1:0] PH_DONE  = 2'd2;

   // Counter slots
   localparam int unsigned CNT_LINES   = 0;
   localparam int unsigned CNT_SEC     = 1;
   localparam int unsigned CNT_PRI     = 2;
   localparam int unsigned CNT_STK     = 3;
   localparam int unsigned CNT_RT      = 4;
   localparam int unsigned CNT_OTHER   = 5;
   localparam int unsigned CNT_KB      = 6;
   localparam int unsigned CNT_KB_SEC  = 7;

   typedef logic [CNT_W-1:0] cnt_type;

   // Hex digit decode: {valid, value}
   function automatic logic [4:0] hex_val(input logic [BYTE_W-1:0] c);
      logic [4:0] r;
      r = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r = {1'b1, 4'(c[3:0] + 4'd9)};
      end
      return r;
   endfunction

   // Saturating add, sticks at the largest 63-bit value
   function automatic cnt_type sat_add(input cnt_type a, input logic [KB_W-1:0] b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + (CNT_W + 1)'(b);
      return s[CNT_W] ? '1 : s[CNT_W-1:0];
   endfunction

endpackage

>>> sv/memory_map_line_classifier.sv
// Top level of the memory map line classifier.
//
// Input stream (req_): one text byte per transfer in req_tdata, req_tlast marks
// the last byte of a stream. Output stream (rsp_): one transfer per completed
// non-empty line and one for the last byte of a stream, carrying the line class
// in rsp_tuser, its KiB size and all running counts and sums in rsp_tdata, and
// rsp_tlast on the result of the stream's last byte (counts are then cleared).
// Bytes that end no line and are not last produce no transfer.
// Throughput: one byte per cycle while the receiver keeps up. A result moves in turn
// through the snapshot, size/class and tally registers after the edge that takes
// its byte.
// Line state updates in the accept cycle; the size subtract sits in the second
// stage and the saturating counter adds in the third.
// Reset clears the line state, counters and all stage valid bits.
// When the receiver stalls, the three stages fill; req_tready then drops until
// rsp_tready frees the output register, and no result is lost.
module memory_map_line_classifier #(
   parameter int unsigned LINE_KEEP = mmlc_pkg::LINE_KEEP_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,   // [7:0] text_byte
   input  logic                             req_tlast,   // stream_end
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [53:0] line_kb, [116:54] lines_total, [179:117] lines_secondary,
   // [242:180] lines_primary, [305:243] lines_stack, [368:306] lines_runtime,
   // [431:369] lines_other, [494:432] kb_total, [557:495] kb_secondary, rest 0
   output logic [mmlc_pkg::OUT_TDATA_W-1:0] rsp_tdata,
   output logic [2:0]                       rsp_tuser,   // [2:0] line_class
   output logic                             rsp_tlast    // stream_done
);

   localparam int unsigned KW = $clog2(LINE_KEEP + 1);
   localparam logic [KW-1:0] KEEP = KW'(LINE_KEEP);
   localparam logic [KW-1:0] KONE = KW'(1);
   localparam int unsigned RW = mmlc_pkg::RANGE_W;
   localparam int unsigned FW = mmlc_pkg::FLAG_W;

   // Reserve check states
   localparam logic [3:0] RCHK_IDLE = 4'd0;
   localparam logic [3:0] RCHK_FIRST = 4'd1;
   localparam logic [3:0] RCHK_LAST = 4'd8;
   localparam logic [3:0] RCHK_DONE = 4'd15;

   // ---------------- line state ----------------
   logic [KW-1:0]              kept_ff, kept_in;
   logic                       stopped_ff, stopped_in;
   logic [3:0]                 rchk_ff, rchk_upd;
   logic [FW-1:0]              flags_ff, flags_upd;
   logic [mmlc_pkg::PH_W-1:0]  phase_ff, phase_upd;
   logic [RW-1:0]              start_ff, start_upd;
   logic [RW-1:0]              end_ff, end_upd;
   logic                       bad_ff, bad_upd;

   logic [7:0] data_b;
   logic       accept, is_nl, room, take, match_step, line_clear, finish, emit;
   logic       sec_hit, pri_hit, stk_hit, rt_hit, rej_set;
   logic [4:0] hex_d;
   logic [7:0] res_char;

   // ---------------- pipeline ----------------
   logic                           a_valid_ff, a_ready, a_ld;
   logic                           a_finish_ff, a_last_ff, a_bad_ff;
   logic [FW-1:0]                  a_flags_ff;
   logic [mmlc_pkg::PH_W-1:0]      a_phase_ff;
   logic [RW-1:0]                  a_start_ff, a_end_ff;

   logic                           b_valid_ff, b_ready, b_ld, b_last_ff;
   logic [mmlc_pkg::CLASS_W-1:0]   b_class_ff, b_class_in;
   logic [mmlc_pkg::KB_W-1:0]      b_kb_ff, b_kb_in;
   logic [RW:0]                    diff;
   logic                           kb_ok;

   logic                           c_ready, c_ld;
   logic                           rsp_valid_ff, rsp_last_ff;
   logic [mmlc_pkg::CLASS_W-1:0]   rsp_class_ff;
   logic [mmlc_pkg::KB_W-1:0]      rsp_kb_ff;
   mmlc_pkg::cnt_type              cnt_ff [mmlc_pkg::CNT_N];
   mmlc_pkg::cnt_type              cnt_new [mmlc_pkg::CNT_N];
   mmlc_pkg::cnt_type              rsp_cnt_ff [mmlc_pkg::CNT_N];
   logic [mmlc_pkg::KB_W-1:0]      one_inc, line_inc, sec_inc, pri_inc, stk_inc;
   logic [mmlc_pkg::KB_W-1:0]      rt_inc, oth_inc, kbsec_inc;

   // ---------------- input decode ----------------
   assign data_b     = req_tdata;
   assign accept     = req_tvalid && req_tready;
   assign is_nl      = (data_b == mmlc_pkg::CHAR_NL);
   assign room       = (kept_ff < KEEP);
   assign take       = accept && !is_nl && room && !stopped_ff;
   assign match_step = take && (data_b != mmlc_pkg::CHAR_NUL);
   assign line_clear = accept && (is_nl || req_tlast);
   // A non-newline byte always leaves a kept byte behind
   assign finish     = accept && (is_nl ? (kept_ff != '0) : req_tlast);
   assign emit       = finish || (accept && req_tlast);

   // Tag matchers
   mmlc_match #(.LEN(mmlc_pkg::SEC_LEN), .PAT(mmlc_pkg::PAT_SEC)) u_match_sec (
      .clock(clock), .reset(reset), .step(match_step), .clear(line_clear),
      .data(data_b), .hit(sec_hit));
   mmlc_match #(.LEN(mmlc_pkg::PRI_LEN), .PAT(mmlc_pkg::PAT_PRI)) u_match_pri (
      .clock(clock), .reset(reset), .step(match_step), .clear(line_clear),
      .data(data_b), .hit(pri_hit));
   mmlc_match #(.LEN(mmlc_pkg::STK_LEN), .PAT(mmlc_pkg::PAT_STK)) u_match_stk (
      .clock(clock), .reset(reset), .step(match_step), .clear(line_clear),
      .data(data_b), .hit(stk_hit));
   mmlc_match #(.LEN(mmlc_pkg::RT_LEN), .PAT(mmlc_pkg::PAT_RT)) u_match_rt (
      .clock(clock), .reset(reset), .step(match_step), .clear(line_clear),
      .data(data_b), .hit(rt_hit));

   // Reserve suffix check after the first primary match
   assign res_char = mmlc_pkg::PAT_RES[{3'(rchk_ff - RCHK_FIRST), 3'b000} +: 8];

   always_comb begin
      rchk_upd = rchk_ff;
      rej_set  = 1'b0;
      if (match_step) begin
         if (rchk_ff >= RCHK_FIRST && rchk_ff <= RCHK_LAST) begin
            if (data_b == res_char) begin
               if (rchk_ff == RCHK_LAST) begin
                  rej_set  = 1'b1;
                  rchk_upd = RCHK_DONE;
               end else begin
                  rchk_upd = rchk_ff + 4'd1;
               end
            end else begin
               rchk_upd = RCHK_DONE;
            end
         end
         if (pri_hit && !flags_ff[mmlc_pkg::FLAG_PRI]) begin
            rchk_upd = RCHK_FIRST;
         end
      end
   end

   always_comb begin
      flags_upd = flags_ff;
      flags_upd[mmlc_pkg::FLAG_SEC] = flags_ff[mmlc_pkg::FLAG_SEC] | sec_hit;
      flags_upd[mmlc_pkg::FLAG_PRI] = flags_ff[mmlc_pkg::FLAG_PRI] | pri_hit;
      flags_upd[mmlc_pkg::FLAG_REJ] = flags_ff[mmlc_pkg::FLAG_REJ] | rej_set;
      flags_upd[mmlc_pkg::FLAG_STK] = flags_ff[mmlc_pkg::FLAG_STK] | stk_hit;
      flags_upd[mmlc_pkg::FLAG_RT]  = flags_ff[mmlc_pkg::FLAG_RT] | rt_hit;
   end

   // Leading hex range "start-end"
   assign hex_d = mmlc_pkg::hex_val(data_b);

   always_comb begin
      phase_upd = phase_ff;
      start_upd = start_ff;
      end_upd   = end_ff;
      bad_upd   = bad_ff;
      if (match_step) begin
         case (phase_ff)
            mmlc_pkg::PH_START: begin
               if (data_b == mmlc_pkg::CHAR_DASH) begin
                  phase_upd = mmlc_pkg::PH_END;
               end else if (hex_d[4]) begin
                  start_upd = {start_ff[RW-5:0], hex_d[3:0]};
               end else begin
                  bad_upd   = 1'b1;
                  phase_upd = mmlc_pkg::PH_DONE;
               end
            end
            mmlc_pkg::PH_END: begin
               if (data_b == mmlc_pkg::CHAR_SPACE) begin
                  phase_upd = mmlc_pkg::PH_DONE;
               end else if (hex_d[4]) begin
                  end_upd = {end_ff[RW-5:0], hex_d[3:0]};
               end else begin
                  bad_upd   = 1'b1;
                  phase_upd = mmlc_pkg::PH_DONE;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign stopped_in = stopped_ff | (take && (data_b == mmlc_pkg::CHAR_NUL));
   assign kept_in    = (accept && !is_nl && room) ? kept_ff + KONE : kept_ff;

   // Line state registers
   always_ff @(posedge clock) begin
      if (reset || line_clear) begin
         kept_ff    <= '0;
         stopped_ff <= 1'b0;
         rchk_ff    <= RCHK_IDLE;
         flags_ff   <= '0;
         phase_ff   <= mmlc_pkg::PH_START;
         start_ff   <= '0;
         end_ff     <= '0;
         bad_ff     <= 1'b0;
      end else if (accept) begin
         kept_ff    <= kept_in;
         stopped_ff <= stopped_in;
         rchk_ff    <= rchk_upd;
         flags_ff   <= flags_upd;
         phase_ff   <= phase_upd;
         start_ff   <= start_upd;
         end_ff     <= end_upd;
         bad_ff     <= bad_upd;
      end
   end

   // ---------------- stage A: line snapshot ----------------
   assign a_ready    = !a_valid_ff || b_ready;
   assign req_tready = a_ready;
   assign a_ld       = emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_ld || (a_valid_ff && !b_ready);
      end
   end

   always_ff @(posedge clock) begin
      if (a_ld) begin
         a_finish_ff <= finish;
         a_last_ff   <= req_tlast;
         a_flags_ff  <= flags_upd;
         a_phase_ff  <= phase_upd;
         a_start_ff  <= start_upd;
         a_end_ff    <= end_upd;
         a_bad_ff    <= bad_upd;
      end
   end

   // ---------------- stage B: size and class ----------------
   assign b_ready = !b_valid_ff || c_ready;
   assign b_ld    = a_valid_ff && b_ready;

   assign diff  = {1'b0, a_end_ff} - {1'b0, a_start_ff};
   assign kb_ok = a_finish_ff && !a_bad_ff && (a_phase_ff != mmlc_pkg::PH_START)
                  && !diff[RW] && (diff[RW-1:0] != '0);
   assign b_kb_in = kb_ok ? diff[RW-1:mmlc_pkg::KIB_SHIFT] : '0;

   // Priority: secondary, primary unless rejected, stack, runtime, other
   always_comb begin
      if (!a_finish_ff) begin
         b_class_in = mmlc_pkg::CLASS_NONE;
      end else if (a_flags_ff[mmlc_pkg::FLAG_SEC]) begin
         b_class_in = mmlc_pkg::CLASS_SECONDARY;
      end else if (a_flags_ff[mmlc_pkg::FLAG_PRI] && !a_flags_ff[mmlc_pkg::FLAG_REJ]) begin
         b_class_in = mmlc_pkg::CLASS_PRIMARY;
      end else if (a_flags_ff[mmlc_pkg::FLAG_STK]) begin
         b_class_in = mmlc_pkg::CLASS_STACK;
      end else if (a_flags_ff[mmlc_pkg::FLAG_RT]) begin
         b_class_in = mmlc_pkg::CLASS_RUNTIME;
      end else begin
         b_class_in = mmlc_pkg::CLASS_OTHER;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_ld || (b_valid_ff && !c_ready);
      end
   end

   always_ff @(posedge clock) begin
      if (b_ld) begin
         b_class_ff <= b_class_in;
         b_kb_ff    <= b_kb_in;
         b_last_ff  <= a_last_ff;
      end
   end

   // ---------------- stage C: tally and output register ----------------
   assign c_ready = !rsp_valid_ff || rsp_tready;
   assign c_ld    = b_valid_ff && c_ready;

   assign one_inc   = mmlc_pkg::KB_W'(1);
   assign line_inc  = (b_class_ff != mmlc_pkg::CLASS_NONE) ? one_inc : '0;
   assign sec_inc   = (b_class_ff == mmlc_pkg::CLASS_SECONDARY) ? one_inc : '0;
   assign pri_inc   = (b_class_ff == mmlc_pkg::CLASS_PRIMARY) ? one_inc : '0;
   assign stk_inc   = (b_class_ff == mmlc_pkg::CLASS_STACK) ? one_inc : '0;
   assign rt_inc    = (b_class_ff == mmlc_pkg::CLASS_RUNTIME) ? one_inc : '0;
   assign oth_inc   = (b_class_ff == mmlc_pkg::CLASS_OTHER) ? one_inc : '0;
   assign kbsec_inc = (b_class_ff == mmlc_pkg::CLASS_SECONDARY) ? b_kb_ff : '0;

   always_comb begin
      cnt_new[mmlc_pkg::CNT_LINES]  = mmlc_pkg::sat_add(cnt_ff[mmlc_pkg::CNT_LINES], line_inc);
      cnt_new[mmlc_pkg::CNT_SEC]    = mmlc_pkg::sat_add(cnt_ff[mmlc_pkg::CNT_SEC], sec_inc);
      cnt_new[mmlc_pkg::CNT_PRI]    = mmlc_pkg::sat_add(cnt_ff[mmlc_pkg::CNT_PRI], pri_inc);
      cnt_new[mmlc_pkg::CNT_STK]    = mmlc_pkg::sat_add(cnt_ff[mmlc_pkg::CNT_STK], stk_inc);
      cnt_new[mmlc_pkg::CNT_RT]     = mmlc_pkg::sat_add(cnt_ff[mmlc_pkg::CNT_RT], rt_inc);
      cnt_new[mmlc_pkg::CNT_OTHER]  = mmlc_pkg::sat_add(cnt_ff[mmlc_pkg::CNT_OTHER], oth_inc);
      cnt_new[mmlc_pkg::CNT_KB]     = mmlc_pkg::sat_add(cnt_ff[mmlc_pkg::CNT_KB], b_kb_ff);
      cnt_new[mmlc_pkg::CNT_KB_SEC] = mmlc_pkg::sat_add(cnt_ff[mmlc_pkg::CNT_KB_SEC],
                                                        kbsec_inc);
   end

   // Running counters; the stream's last result clears them after reporting
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mmlc_pkg::CNT_N; i++) begin
            cnt_ff[i] <= '0;
         end
      end else if (c_ld) begin
         for (int i = 0; i < mmlc_pkg::CNT_N; i++) begin
            cnt_ff[i] <= b_last_ff ? '0 : cnt_new[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= c_ld || (rsp_valid_ff && !rsp_tready);
      end
   end

   always_ff @(posedge clock) begin
      if (c_ld) begin
         rsp_class_ff <= b_class_ff;
         rsp_kb_ff    <= b_kb_ff;
         rsp_last_ff  <= b_last_ff;
         for (int i = 0; i < mmlc_pkg::CNT_N; i++) begin
            rsp_cnt_ff[i] <= cnt_new[i];
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_class_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{mmlc_pkg::OUT_PAD_W{1'b0}},
                        rsp_cnt_ff[mmlc_pkg::CNT_KB_SEC], rsp_cnt_ff[mmlc_pkg::CNT_KB],
                        rsp_cnt_ff[mmlc_pkg::CNT_OTHER], rsp_cnt_ff[mmlc_pkg::CNT_RT],
                        rsp_cnt_ff[mmlc_pkg::CNT_STK], rsp_cnt_ff[mmlc_pkg::CNT_PRI],
                        rsp_cnt_ff[mmlc_pkg::CNT_SEC], rsp_cnt_ff[mmlc_pkg::CNT_LINES],
                        rsp_kb_ff};

endmodule

>>> sv/mmlc_match.sv
// Streaming substring matcher for one fixed tag pattern.
module mmlc_match #(
   parameter int unsigned LEN = 8,
   parameter logic [LEN*8-1:0] PAT = '0
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,    // byte takes part in matching
   input  logic       clear,   // line ends
   input  logic [7:0] data,
   output logic       hit      // this byte completes the pattern
);

   localparam int unsigned PW = $clog2(LEN);
   localparam logic [PW-1:0] ONE = PW'(1);
   localparam logic [PW-1:0] LAST_POS = PW'(LEN - 1);

   logic [PW-1:0] pos_ff, pos_in;
   logic [7:0]    cur_char;
   logic          is_cur;
   logic          at_last;

   assign cur_char = PAT[{pos_ff, 3'b000} +: 8];
   assign is_cur   = (data == cur_char);
   assign at_last  = (pos_ff == LAST_POS);
   assign hit      = step && is_cur && at_last;

   // A mismatch restarts, an opening bracket starts a fresh attempt
   always_comb begin
      pos_in = pos_ff;
      if (clear) begin
         pos_in = '0;
      end else if (step) begin
         if (is_cur) begin
            pos_in = at_last ? '0 : pos_ff + ONE;
         end else if (data == mmlc_pkg::CHAR_LBRACK) begin
            pos_in = ONE;
         end else begin
            pos_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

>>> sv/mmlc_checker.sv
// Port-level checker of the memory map line classifier and its bind.
module mmlc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [mmlc_pkg::OUT_TDATA_W-1:0] rsp_tdata,
   input logic [2:0]                       rsp_tuser,
   input logic                             rsp_tlast
);

   localparam int unsigned KB_W  = mmlc_pkg::KB_W;
   localparam int unsigned CNT_W = mmlc_pkg::CNT_W;

   logic [KB_W-1:0]  line_kb;
   logic [CNT_W-1:0] lines_total, kb_total, kb_secondary;

   assign line_kb      = rsp_tdata[KB_W-1:0];
   assign lines_total  = rsp_tdata[KB_W + CNT_W-1:KB_W];
   assign kb_total     = rsp_tdata[KB_W + 7*CNT_W-1:KB_W + 6*CNT_W];
   assign kb_secondary = rsp_tdata[KB_W + 8*CNT_W-1:KB_W + 7*CNT_W];

   // Nothing is offered right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // A stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // A result without a line only comes for the stream end and has no size
   a_noline: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == mmlc_pkg::CLASS_NONE |-> rsp_tlast && line_kb == '0)
      else $error("lineless result outside stream end");

   // A completed line is counted and its size is in the running sum
   a_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != mmlc_pkg::CLASS_NONE |->
      lines_total != '0 && kb_total >= CNT_W'(line_kb))
      else $error("completed line missing from running totals");

   // Secondary size sum never exceeds the total size sum
   a_kb_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> kb_secondary <= kb_total)
      else $error("secondary KiB sum above total");

endmodule

bind memory_map_line_classifier mmlc_checker u_mmlc_checker (.*);
